/* rtl/fthp_pkg.sv */
// ----------------------------------------------------------------------------
// fthp_pkg
// Shared constants and types for the FLV tag header parser.
// ----------------------------------------------------------------------------
package fthp_pkg;

  // Byte counts of the FLV container layout
  localparam int unsigned SkipStart  = 13;  // file header plus first previous-tag-size
  localparam int unsigned HdrLen     = 11;  // tag header length
  localparam int unsigned TrailerLen = 4;   // previous-tag-size after each body

  // Datapath widths
  localparam int unsigned SkipW = 25;
  localparam int unsigned FillW = 4;
  localparam int unsigned LenW  = 24;

  // One decoded tag header
  typedef struct packed {
    logic [7:0]      tag_type;
    logic [LenW-1:0] body_length;
    logic [31:0]     tag_time;
    logic [23:0]     stream_number;
  } tag_hdr_t;

endpackage

/* rtl/fthp_if.sv */
// ----------------------------------------------------------------------------
// fthp_if
// Valid/ready channels of the FLV tag header parser: the raw byte stream
// and the decoded tag header stream.
// ----------------------------------------------------------------------------
interface fthp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface fthp_tag_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tag_type;
  logic [23:0] body_length;
  logic [31:0] tag_time;
  logic [23:0] stream_number;

  modport source (output valid, output tag_type, output body_length,
                  output tag_time, output stream_number, input ready);
  modport sink   (input valid, input tag_type, input body_length,
                  input tag_time, input stream_number, output ready);
endinterface

/* rtl/fthp_core.sv */
// ----------------------------------------------------------------------------
// fthp_core
// Skip countdown, header capture store and header decode. Advances by one
// byte on each step; flags the byte that completes a tag header.
// ----------------------------------------------------------------------------
module fthp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output logic                emit_o,
  output fthp_pkg::tag_hdr_t  hdr_o
);

  logic [fthp_pkg::SkipW-1:0] skip_q, skip_d;
  logic                       coll_q, coll_d;
  logic [fthp_pkg::FillW-1:0] fill_q, fill_d;
  logic [fthp_pkg::FillW-1:0] fill_eff;
  logic                       last_byte;
  // last header byte is taken straight from the input, so one entry less
  logic [7:0]                 hb_q [fthp_pkg::HdrLen-1];

  // Out-of-range fill restarts capture at byte 0
  assign fill_eff  = (fill_q >= fthp_pkg::FillW'(fthp_pkg::HdrLen)) ? '0 : fill_q;
  assign last_byte = coll_q && (fill_eff == fthp_pkg::FillW'(fthp_pkg::HdrLen - 1));
  assign emit_o    = last_byte;

  // Header decode, big-endian fields
  always_comb begin
    hdr_o.tag_type      = hb_q[0];
    hdr_o.body_length   = {hb_q[1], hb_q[2], hb_q[3]};
    hdr_o.tag_time      = {hb_q[7], hb_q[4], hb_q[5], hb_q[6]};
    hdr_o.stream_number = {hb_q[8], hb_q[9], byte_i};
  end

  // Next state
  always_comb begin
    skip_d = skip_q;
    coll_d = coll_q;
    fill_d = fill_q;
    if (!coll_q) begin
      if (skip_q > fthp_pkg::SkipW'(1)) begin
        skip_d = skip_q - fthp_pkg::SkipW'(1);
      end else begin
        skip_d = '0;
        coll_d = 1'b1;
        fill_d = '0;
      end
    end else if (last_byte) begin
      fill_d = '0;
      coll_d = 1'b0;
      skip_d = {1'b0, hdr_o.body_length} + fthp_pkg::SkipW'(fthp_pkg::TrailerLen);
    end else begin
      fill_d = fill_eff + fthp_pkg::FillW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= fthp_pkg::SkipW'(fthp_pkg::SkipStart);
      coll_q <= 1'b0;
      fill_q <= '0;
    end else if (step_i) begin
      skip_q <= skip_d;
      coll_q <= coll_d;
      fill_q <= fill_d;
    end
  end

  // Capture store, written at the fill position
  always_ff @(posedge clk_i) begin
    if (step_i && coll_q && !last_byte) begin
      hb_q[fill_eff] <= byte_i;
    end
  end

  // Fill never runs past the header length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < fthp_pkg::FillW'(fthp_pkg::HdrLen))
    else $error("fthp_core: fill count out of range");

  // Fill stays at zero while skipping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !coll_q |-> fill_q == '0)
    else $error("fthp_core: fill count nonzero while skipping");

  // A completed header leaves a skip of at least the trailer length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o |=> !coll_q && skip_q >= fthp_pkg::SkipW'(fthp_pkg::TrailerLen))
    else $error("fthp_core: bad skip after header");

endmodule

/* rtl/flv_tag_header_parser.sv */
// ----------------------------------------------------------------------------
// flv_tag_header_parser
// FLV tag header extractor: byte stream in, one decoded tag header out
// per tag.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries the FLV file one byte per transaction (valid/ready).
//   The first 13 bytes (file header and first previous-tag-size) are
//   dropped. Each following 11-byte tag header yields one transaction on
//   tag_o with tag type, body length, timestamp and stream id; the body
//   and its trailing previous-tag-size are then skipped by countdown.
//   Path: the last header byte passes the input register, then the result
//   register, before tag_o.valid rises.
//   Throughput: one byte per cycle, by the countdown and capture step
//   between the two registers, unless tag_o stalls a completing byte.
//   Reset: asynchronous, active low; the parser restarts at the file
//   header and both registers empty.
//   Stall: while tag_o holds a result that is not taken, bytes that do not
//   complete a header still flow; the byte that completes the next header
//   waits in the input register, and byte_i.ready drops behind it.
// ----------------------------------------------------------------------------
module flv_tag_header_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  fthp_byte_if.sink     byte_i,
  fthp_tag_if.source    tag_o
);

  logic               in_vld_q;
  logic [7:0]         in_byte_q;
  logic               out_vld_q;
  fthp_pkg::tag_hdr_t out_hdr_q;
  fthp_pkg::tag_hdr_t hdr;
  logic               emit;
  logic               adv;

  fthp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (in_byte_q),
    .emit_o (emit),
    .hdr_o  (hdr)
  );

  // Process the buffered byte unless its result has nowhere to go
  assign adv          = in_vld_q && (!emit || !out_vld_q || tag_o.ready);
  assign byte_i.ready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.stream_byte;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && emit) begin
      out_vld_q <= 1'b1;
    end else if (tag_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_hdr_q <= hdr;
    end
  end

  assign tag_o.valid         = out_vld_q;
  assign tag_o.tag_type      = out_hdr_q.tag_type;
  assign tag_o.body_length   = out_hdr_q.body_length;
  assign tag_o.tag_time      = out_hdr_q.tag_time;
  assign tag_o.stream_number = out_hdr_q.stream_number;

  // A buffered byte that is held back keeps its slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_byte_q))
    else $error("flv_tag_header_parser: held byte lost");

  // A held-back byte is always a header-completing byte facing a full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |-> emit && out_vld_q && !tag_o.ready)
    else $error("flv_tag_header_parser: spurious stall");

  // A new result is loaded only when the slot frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |=> out_vld_q)
    else $error("flv_tag_header_parser: result dropped");

endmodule
